// File: rtl/core/lagrange_interpolation_eval_assert.svh
// Assertion macros for the interpolation core
`ifndef LAGRANGE_INTERPOLATION_EVAL_ASSERT_SVH
`define LAGRANGE_INTERPOLATION_EVAL_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle
`define LIE_ASSERT_IMP(lbl, clk, rstn, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (cons)) \
    else $error("assertion failed");

// Check that a condition implies a consequence in the next cycle
`define LIE_ASSERT_NEXT(lbl, clk, rstn, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/core/lie_pkg.sv
// ----------------------------------------------------------------------------
// lie_pkg
// Shared types and constants of the Lagrange interpolation evaluator.
// ----------------------------------------------------------------------------
package lie_pkg;

  localparam int unsigned MaxNodesDefault = 8;
  localparam int unsigned FracBitsDefault = 16;
  localparam int unsigned CountW          = 4;
  localparam logic [3:0]  CountReset      = 4'd7;

  localparam logic [1:0] StatusOk  = 2'd0;
  localparam logic [1:0] StatusOvf = 2'd1;
  localparam logic [1:0] StatusDup = 2'd2;

  localparam logic ModeLoad = 1'b0;
  localparam logic ModeEval = 1'b1;

  typedef enum logic [3:0] {
    StIdle,
    StDupRd,
    StDupCmp,
    StTermRd,
    StPairRd,
    StDivInit,
    StDiv,
    StDivSat,
    StMulP,
    StMulY,
    StAcc,
    StDone
  } state_e;

endpackage

// File: rtl/core/lagrange_interpolation_eval.sv
// ----------------------------------------------------------------------------
// lagrange_interpolation_eval
// Lagrange polynomial evaluation over stored nodes, signed fixed point.
// ----------------------------------------------------------------------------
// channel   | direction | handshake          | payload
// command   | in        | start_i / busy_o   | mode, node_index, x, y, point
// result    | out       | result_valid_o     | interp_value, status
// config    | in        | cfg_valid_i/ready  | node_count
//
// A load is taken while idle and busy_o stays low. An evaluate holds busy_o
// high while it runs; its divisions go through the one shared restoring divider
// (DW = 33 + FRAC_BITS dividend bits) that produces one quotient bit per cycle;
// the result strobe comes in the same cycle that busy_o falls.
// Node tables are not reset; the node count resets to 7.
// The result strobe lasts one cycle; the receiver cannot stall.
module lagrange_interpolation_eval #(
  parameter int unsigned MAX_NODES = lie_pkg::MaxNodesDefault,
  parameter int unsigned FRAC_BITS = lie_pkg::FracBitsDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic                     mode_i,
  input  logic [2:0]               node_index_i,
  input  logic signed [31:0]       node_x_value_i,
  input  logic signed [31:0]       node_y_value_i,
  input  logic signed [31:0]       eval_point_i,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [lie_pkg::CountW-1:0] cfg_data_i,
  output logic                     result_valid_o,
  output logic signed [31:0]       interp_value_o,
  output logic [1:0]               status_o
);

  localparam int unsigned IdxW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned CntW = $clog2(MAX_NODES + 1);
  // dividend magnitude width: |num| < 2^33, shifted by FRAC_BITS
  localparam int unsigned DW   = 33 + FRAC_BITS;
  localparam int unsigned DCW  = $clog2(DW + 1);
  localparam logic signed [63:0] QMax = 64'sd2147483647;
  localparam logic signed [63:0] QMin = -64'sd2147483648;

  logic signed [31:0] x_mem [MAX_NODES];
  logic signed [31:0] y_mem [MAX_NODES];

  lie_pkg::state_e state_q, state_d;
  logic [lie_pkg::CountW-1:0] count_q;
  logic [IdxW-1:0]  j_q, j_d, k_q, k_d;
  logic [CntW-1:0]  n_q;
  logic signed [31:0] pt_q, xj_q, xk_q, yj_q, rdx_q, rdy_q;
  logic signed [31:0] p_q, acc_q;
  logic [DW-1:0]    dvd_q, quo_q;
  logic [33:0]      dvs_q, rem_q;
  logic             neg_q, ovf_q, dup_q;
  logic [DCW-1:0]   dcnt_q;
  logic signed [63:0] prod_q;
  logic signed [31:0] q_q;
  logic             rd_en;
  logic [IdxW-1:0]  rd_addr;

  // ---------------- configuration ----------------
  assign cfg_ready_o = (state_q == lie_pkg::StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= lie_pkg::CountReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      count_q <= cfg_data_i;
    end
  end

  // ---------------- node memory ----------------
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o && mode_i == lie_pkg::ModeLoad &&
        32'(node_index_i) < MAX_NODES) begin
      x_mem[IdxW'(node_index_i)] <= node_x_value_i;
      y_mem[IdxW'(node_index_i)] <= node_y_value_i;
    end
    if (rd_en) begin
      rdx_q <= x_mem[rd_addr];
      rdy_q <= y_mem[rd_addr];
    end
  end

  assign busy_o = (state_q != lie_pkg::StIdle);

  // ---------------- sequencer ----------------
  logic last_k, last_j, skip_k;
  assign last_k = (32'(k_q) + 1 >= 32'(n_q));
  assign last_j = (32'(j_q) + 1 >= 32'(n_q));

  always_comb begin
    state_d = state_q;
    j_d = j_q;
    k_d = k_q;
    rd_en = 1'b0;
    rd_addr = k_q;
    skip_k = 1'b0;
    unique case (state_q)
      lie_pkg::StIdle: begin
        if (start_i && mode_i == lie_pkg::ModeEval) begin
          state_d = lie_pkg::StDupRd;
          j_d = '0;
          k_d = '0;
        end
      end
      lie_pkg::StDupRd: begin
        rd_en = 1'b1;
        state_d = lie_pkg::StDupCmp;
      end
      lie_pkg::StDupCmp: begin
        // rdx_q holds node k; xj_q holds node j (captured at k == j)
        if (last_k) begin
          if (last_j) begin
            state_d = lie_pkg::StTermRd;
            j_d = '0;
            k_d = '0;
          end else begin
            j_d = j_q + 1'b1;
            k_d = '0;
            state_d = lie_pkg::StDupRd;
          end
        end else begin
          k_d = k_q + 1'b1;
          state_d = lie_pkg::StDupRd;
        end
        if (dup_q) state_d = lie_pkg::StDone;
      end
      lie_pkg::StTermRd: begin
        rd_en = 1'b1;
        rd_addr = j_q;
        state_d = lie_pkg::StPairRd;
      end
      lie_pkg::StPairRd: begin
        rd_en = 1'b1;
        if (k_q == j_q) begin
          skip_k = 1'b1;
          if (last_k) state_d = lie_pkg::StMulY;
          else k_d = k_q + 1'b1;
        end else begin
          state_d = lie_pkg::StDivInit;
        end
      end
      lie_pkg::StDivInit: state_d = lie_pkg::StDiv;
      lie_pkg::StDiv: if (dcnt_q == '0) state_d = lie_pkg::StDivSat;
      lie_pkg::StDivSat: state_d = lie_pkg::StMulP;
      lie_pkg::StMulP: begin
        if (last_k) state_d = lie_pkg::StMulY;
        else begin
          k_d = k_q + 1'b1;
          state_d = lie_pkg::StPairRd;
        end
      end
      lie_pkg::StMulY: state_d = lie_pkg::StAcc;
      lie_pkg::StAcc: begin
        if (last_j) state_d = lie_pkg::StDone;
        else begin
          j_d = j_q + 1'b1;
          k_d = '0;
          state_d = lie_pkg::StTermRd;
        end
      end
      lie_pkg::StDone: state_d = lie_pkg::StIdle;
      default: state_d = lie_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lie_pkg::StIdle;
      j_q <= '0;
      k_q <= '0;
    end else begin
      state_q <= state_d;
      j_q <= j_d;
      k_q <= k_d;
    end
  end

  // ---------------- datapath ----------------
  logic signed [32:0] num_w, den_w;
  logic [34:0] rem_sh;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p, fl_p, sum_w;
  logic signed [DW:0] qs_w;

  assign num_w = 33'(pt_q) - 33'(rdx_q);
  assign den_w = 33'(xj_q) - 33'(rdx_q);
  assign rem_sh = {rem_q, dvd_q[DW-1]};
  assign fl_p = prod_q >>> FRAC_BITS;
  assign sum_w = 64'(acc_q) + fl_p;
  assign qs_w = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
  assign mul_a = (state_q == lie_pkg::StMulY) ? yj_q : p_q;
  assign mul_b = (state_q == lie_pkg::StMulY) ? p_q : q_q;
  assign mul_p = 64'(mul_a) * 64'(mul_b);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
      dup_q <= 1'b0;
      ovf_q <= 1'b0;
      dcnt_q <= '0;
    end else begin
      result_valid_o <= 1'b0;
      unique case (state_q)
        lie_pkg::StIdle: begin
          pt_q <= eval_point_i;
          dup_q <= 1'b0;
          ovf_q <= 1'b0;
          acc_q <= '0;
          if (count_q == '0) n_q <= CntW'(1);
          else if (32'(count_q) > MAX_NODES) n_q <= CntW'(MAX_NODES);
          else n_q <= CntW'(count_q);
        end
        lie_pkg::StDupCmp: begin
          if (k_q == j_q) xj_q <= rdx_q;
          else if (k_q > j_q && rdx_q == xj_q) dup_q <= 1'b1;
        end
        lie_pkg::StPairRd: begin
          if (32'(k_q) == 0) begin
            xj_q <= rdx_q;
            yj_q <= rdy_q;
            p_q <= 32'(64'sd1 <<< FRAC_BITS);
          end
        end
        lie_pkg::StDivInit: begin
          // divide magnitudes, restoring, one bit a cycle
          dvd_q <= DW'(num_w[32] ? -num_w : num_w) << FRAC_BITS;
          dvs_q <= 34'(den_w[32] ? -den_w : den_w);
          neg_q <= num_w[32] ^ den_w[32];
          rem_q <= '0;
          quo_q <= '0;
          dcnt_q <= DCW'(DW);
        end
        lie_pkg::StDiv: begin
          if (dcnt_q != '0) begin
            if (rem_sh >= {1'b0, dvs_q}) rem_q <= 34'(rem_sh - {1'b0, dvs_q});
            else rem_q <= rem_sh[33:0];
            quo_q <= {quo_q[DW-2:0], (rem_sh >= {1'b0, dvs_q})};
            dvd_q <= dvd_q << 1;
            dcnt_q <= dcnt_q - 1'b1;
          end
        end
        lie_pkg::StDivSat: begin
          if (qs_w > (DW+1)'(QMax)) begin
            q_q <= 32'(QMax);
            ovf_q <= 1'b1;
          end else if (qs_w < (DW+1)'(QMin)) begin
            q_q <= 32'(QMin);
            ovf_q <= 1'b1;
          end else q_q <= 32'(qs_w);
          prod_q <= '0;
        end
        lie_pkg::StMulP: begin
          p_q <= (mul_p >>> FRAC_BITS) > QMax ? 32'(QMax) :
                 (mul_p >>> FRAC_BITS) < QMin ? 32'(QMin) :
                 32'(mul_p >>> FRAC_BITS);
          if ((mul_p >>> FRAC_BITS) > QMax || (mul_p >>> FRAC_BITS) < QMin)
            ovf_q <= 1'b1;
        end
        lie_pkg::StMulY: prod_q <= mul_p;
        lie_pkg::StAcc: begin
          if (fl_p > QMax || fl_p < QMin) begin
            ovf_q <= 1'b1;
            if ((fl_p > QMax ? QMax : QMin) + 64'(acc_q) > QMax) acc_q <= 32'(QMax);
            else if ((fl_p > QMax ? QMax : QMin) + 64'(acc_q) < QMin)
              acc_q <= 32'(QMin);
            else acc_q <= 32'((fl_p > QMax ? QMax : QMin) + 64'(acc_q));
          end else if (sum_w > QMax) begin
            acc_q <= 32'(QMax);
            ovf_q <= 1'b1;
          end else if (sum_w < QMin) begin
            acc_q <= 32'(QMin);
            ovf_q <= 1'b1;
          end else acc_q <= 32'(sum_w);
        end
        lie_pkg::StDone: begin
          result_valid_o <= 1'b1;
          interp_value_o <= dup_q ? '0 : acc_q;
          status_o <= dup_q ? lie_pkg::StatusDup :
                      (ovf_q ? lie_pkg::StatusOvf : lie_pkg::StatusOk);
        end
        default: ;
      endcase
    end
  end

  `include "lagrange_interpolation_eval_assert.svh"

  `LIE_ASSERT_NEXT(a_done_strobe, clk_i, rst_ni,
                   state_q == lie_pkg::StDone, result_valid_o)
  `LIE_ASSERT_IMP(a_strobe_idle, clk_i, rst_ni, result_valid_o, !busy_o)
  `LIE_ASSERT_IMP(a_cfg_idle, clk_i, rst_ni, cfg_ready_o, !busy_o)
  `LIE_ASSERT_NEXT(a_load_nores, clk_i, rst_ni,
                   start_i && !busy_o && mode_i == lie_pkg::ModeLoad, !busy_o)

endmodule

// File: tb/sv/tb_lagrange_interpolation_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lagrange_interpolation_eval
// Self-checking bench for the Lagrange evaluator: node loads and evaluations
// go in through the command port, each evaluation is predicted in Q16.16 and
// checked field by field when its strobe comes out.
// ----------------------------------------------------------------------------
module tb_lagrange_interpolation_eval;

  localparam int unsigned NodeSlots  = 8;
  localparam int unsigned FracW      = 16;
  localparam longint      QMax       = 64'sd2147483647;
  localparam longint      QMin       = -64'sd2147483648;
  localparam longint      CycleLimit = 4000000;

  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         status;
  } interp_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic               mode_i = lie_pkg::ModeLoad;
  logic [2:0]         node_index_i = '0;
  logic signed [31:0] node_x_value_i = '0;
  logic signed [31:0] node_y_value_i = '0;
  logic signed [31:0] eval_point_i = '0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [lie_pkg::CountW-1:0] cfg_data_i = '0;
  logic               result_valid_o;
  logic signed [31:0] interp_value_o;
  logic [1:0]         status_o;

  lagrange_interpolation_eval uut (.*);

  always #2 clk_i = ~clk_i;

  // Predictor state
  logic signed [31:0] x_nodes [NodeSlots];
  logic signed [31:0] y_nodes [NodeSlots];
  bit                 slot_loaded [NodeSlots];
  logic [lie_pkg::CountW-1:0] used_count = lie_pkg::CountReset;
  bit                 sat_hit;

  interp_result_t pending_results[$];
  int   errors = 0;
  int   results_seen = 0;
  int   loads_sent = 0;
  int   evals_sent = 0;
  int   burst_left = 0;
  longint cycles = 0;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results pending", cycles,
               pending_results.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic report(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    errors++;
  endtask

  function automatic longint clamp32(input longint v);
    if (v > QMax) begin
      sat_hit = 1'b1;
      return QMax;
    end
    if (v < QMin) begin
      sat_hit = 1'b1;
      return QMin;
    end
    return v;
  endfunction

  function automatic int nodes_in_use();
    if (used_count == 0) return 1;
    if (used_count > NodeSlots) return NodeSlots;
    return int'(used_count);
  endfunction

  function automatic interp_result_t interpolate_at(input logic signed [31:0] pt);
    interp_result_t r;
    longint acc, p, q, num, den;
    int n;
    n = nodes_in_use();
    sat_hit = 1'b0;
    for (int j = 0; j < n; j++)
      for (int k = j + 1; k < n; k++)
        if (x_nodes[j] == x_nodes[k]) begin
          r.value = '0;
          r.status = lie_pkg::StatusDup;
          return r;
        end
    acc = 0;
    for (int j = 0; j < n; j++) begin
      p = longint'(1) <<< FracW;
      for (int k = 0; k < n; k++) begin
        if (k == j) continue;
        num = longint'(pt) - longint'(x_nodes[k]);
        den = longint'(x_nodes[j]) - longint'(x_nodes[k]);
        q = clamp32((num <<< FracW) / den);
        p = clamp32((p * q) >>> FracW);
      end
      acc = clamp32(acc + clamp32((longint'(y_nodes[j]) * p) >>> FracW));
    end
    r.value = acc[31:0];
    r.status = sat_hit ? lie_pkg::StatusOvf : lie_pkg::StatusOk;
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      interp_result_t want;
      results_seen++;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result value=%h status=%0d",
                         interp_value_o, status_o));
      end else begin
        want = pending_results.pop_front();
        if (interp_value_o !== want.value)
          report($sformatf("value got %h want %h", interp_value_o, want.value));
        if (status_o !== want.status)
          report($sformatf("status got %0d want %0d", status_o, want.status));
      end
    end
  end

  // Drive one command beat and hold it until the block takes it.
  task automatic send_beat(input logic md, input logic [2:0] slot,
                           input logic signed [31:0] nx, input logic signed [31:0] ny,
                           input logic signed [31:0] pt);
    start_i        <= 1'b1;
    mode_i         <= md;
    node_index_i   <= slot;
    node_x_value_i <= nx;
    node_y_value_i <= ny;
    eval_point_i   <= pt;
    do @(posedge clk_i); while (busy_o);
    if (md == lie_pkg::ModeLoad) begin
      x_nodes[slot] = nx;
      y_nodes[slot] = ny;
      slot_loaded[slot] = 1'b1;
      loads_sent++;
    end else begin
      pending_results.push_back(interpolate_at(pt));
      evals_sent++;
    end
    // burst pacing: keep start high inside a burst, drop it for a gap
    if (burst_left == 0) begin
      int gap;
      burst_left = $urandom_range(1, 10);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 25) : $urandom_range(0, 2);
      if (gap > 0) begin
        start_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic load_node(input logic [2:0] slot, input logic signed [31:0] nx,
                           input logic signed [31:0] ny);
    send_beat(lie_pkg::ModeLoad, slot, nx, ny, $urandom);
  endtask

  task automatic eval_point(input logic signed [31:0] pt);
    send_beat(lie_pkg::ModeEval, 3'($urandom), $urandom, $urandom, pt);
  endtask

  task automatic wait_drained();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0 || busy_o) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_count(input logic [lie_pkg::CountW-1:0] v);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    used_count = v;
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic signed [31:0] rand_q();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6)
      return (32'($signed($urandom_range(0, 12)) - 6) <<< FracW) + $urandom_range(0, 65535);
    if (sel < 8)
      return (32'($signed($urandom_range(0, 2000)) - 1000) <<< FracW) + $urandom_range(0, 65535);
    return $urandom;
  endfunction

  // Count 0 acts as one node: the result is just y of slot 0.
  task automatic test_single_node();
    write_count(4'd0);
    load_node(3'd0, 32'sh0001_0000, 32'sh7FFF_FFFF);
    eval_point(32'sh8000_0000);
    load_node(3'd0, 32'sh8000_0000, 32'sh8000_0000);
    eval_point(32'sh7FFF_FFFF);
    write_count(4'd1);
    eval_point(32'sh0000_0000);
  endtask

  // Two nodes sharing an abscissa give the duplicate status.
  task automatic test_duplicate();
    write_count(4'd2);
    load_node(3'd1, 32'sh8000_0000, 32'sh0003_0000);
    eval_point(32'sh0002_8000);
    load_node(3'd1, 32'sh0004_0000, 32'sh0003_0000);
    eval_point(32'sh0002_8000);
  endtask

  // Extreme abscissae and ordinates force saturation in quotients and sums.
  task automatic test_overflow();
    load_node(3'd0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    load_node(3'd1, 32'sh8000_0000, 32'sh7FFF_FFFF);
    eval_point(32'sh7FFF_FFFF);
    load_node(3'd0, 32'sh0000_0001, 32'sh7FFF_FFFF);
    load_node(3'd1, 32'sh0000_0000, 32'sh8000_0000);
    eval_point(32'sh7000_0000);
  endtask

  // Fill every slot and use all of them, then ask for more than exist.
  task automatic test_full_table();
    for (int s = 0; s < NodeSlots; s++)
      load_node(s[2:0], (32'(s) - 3) <<< FracW, 32'(s * s) <<< FracW);
    write_count(4'd8);
    eval_point(32'sh0000_8000);
    write_count(4'd15);
    eval_point(32'shFFFE_4000);
  endtask

  task automatic test_random(input int items);
    int done_items;
    int n;
    done_items = 0;
    while (done_items < items) begin
      // most phases use few nodes to keep the serial divider cheap
      case ($urandom_range(0, 9))
        0:       write_count(4'd8);
        1:       write_count(4'($urandom_range(9, 15)));
        2:       write_count(4'd0);
        default: write_count(4'($urandom_range(1, 5)));
      endcase
      n = nodes_in_use();
      for (int s = 0; s < n; s++) begin
        load_node(s[2:0], ((32'(2 * s) - 32'(n)) <<< FracW) + $urandom_range(0, 65535),
                  rand_q());
        done_items++;
      end
      repeat ($urandom_range(10, 35)) begin
        if ($urandom_range(0, 99) < 30)
          load_node(3'($urandom_range(0, 7)), rand_q(), rand_q());
        else
          eval_point(rand_q());
        done_items++;
      end
    end
  endtask

  initial begin
    for (int s = 0; s < NodeSlots; s++) begin
      x_nodes[s] = '0;
      y_nodes[s] = '0;
      slot_loaded[s] = 1'b0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_node();
    test_duplicate();
    test_overflow();
    test_full_table();
    test_random(245);

    wait_drained();
    repeat (50) @(posedge clk_i);
    $display("covered %0d loads and %0d evaluations, %0d results checked",
             loads_sent, evals_sent, results_seen);
    $display("node counts 0..15, duplicate abscissae, saturation, random bursts");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: lagrange_interpolation_eval.f
+incdir+rtl/core
rtl/core/lie_pkg.sv
rtl/core/lagrange_interpolation_eval.sv
tb/sv/tb_lagrange_interpolation_eval.sv
